// File: rtl/box_tracking_stick_controller_core_assert.svh
// Assertion macros for the stick controller checker.
`ifndef BOX_TRACKING_STICK_CONTROLLER_CORE_ASSERT_SVH
`define BOX_TRACKING_STICK_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BTSC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("btsc check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BTSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("btsc check failed");

`endif

// File: rtl/btsc_pkg.sv
`default_nettype none

package btsc_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_SQRT,
        ST_RATIO_GO,
        ST_RATIO,
        ST_ALPHA_MUL,
        ST_ALPHA,
        ST_DIV_GO,
        ST_DIV,
        ST_FILT_MUL,
        ST_FILT_ADD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    localparam int DIV_NUM_W   = 56;
    localparam int DIV_DEN_W   = 34;
    localparam int SQRT_IN_W   = 56;
    localparam int SQRT_ROOT_W = 28;

    localparam longint unsigned TILT_Q24 = 64'd10248618;
    localparam int PITCH_OFFSET_Q16 = 18725;
    localparam int ONE_Q16          = 65536;
    localparam int HALF_Q16         = 32768;

    localparam logic [2:0] REG_ALPHA_MIN  = 3'd0;
    localparam logic [2:0] REG_ALPHA_MAX  = 3'd1;
    localparam logic [2:0] REG_FULL_ERROR = 3'd2;
    localparam logic [2:0] REG_TILT_GAIN  = 3'd3;
    localparam logic [2:0] REG_TURN_GAIN  = 3'd4;
    localparam logic [2:0] REG_AIM_X      = 3'd5;
    localparam logic [2:0] REG_AIM_Y      = 3'd6;
    localparam logic [2:0] REG_MIN_CONF   = 3'd7;

    localparam logic [1:0] CH_ROLL  = 2'd0;
    localparam logic [1:0] CH_PITCH = 2'd1;
    localparam logic [1:0] CH_YAW   = 2'd2;
    localparam logic [1:0] CH_THR   = 2'd3;

endpackage

`default_nettype wire

// File: rtl/btsc_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module btsc_div (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [btsc_pkg::DIV_NUM_W-1:0]      num,
    input  wire logic [btsc_pkg::DIV_DEN_W-1:0]      den,
    output logic [btsc_pkg::DIV_NUM_W-1:0]           quo,
    output btsc_pkg::unit_stat_t                     stat
);

    localparam int CNT_W = $clog2(btsc_pkg::DIV_NUM_W + 1);

    logic [btsc_pkg::DIV_DEN_W-1:0] rem_reg;
    logic [btsc_pkg::DIV_NUM_W-1:0] quo_reg;
    logic [btsc_pkg::DIV_DEN_W-1:0] den_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    logic [btsc_pkg::DIV_DEN_W:0]   rem_sh;
    logic [btsc_pkg::DIV_DEN_W:0]   rem_sub;
    logic                           ge;

    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[btsc_pkg::DIV_NUM_W-1]};
        ge      = rem_sh >= {1'b0, den_reg};
        rem_sub = rem_sh - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(btsc_pkg::DIV_NUM_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sub[btsc_pkg::DIV_DEN_W-1:0]
                          : rem_sh[btsc_pkg::DIV_DEN_W-1:0];
            quo_reg <= {quo_reg[btsc_pkg::DIV_NUM_W-2:0], ge};
        end
    end

    assign quo       = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

// File: rtl/btsc_sqrt.sv
`default_nettype none

// Integer square root, two radicand bits per cycle.
module btsc_sqrt (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [btsc_pkg::SQRT_IN_W-1:0]      rad,
    output logic [btsc_pkg::SQRT_ROOT_W-1:0]         root,
    output btsc_pkg::unit_stat_t                     stat
);

    localparam int RW    = btsc_pkg::SQRT_ROOT_W;
    localparam int REM_W = RW + 2;
    localparam int CNT_W = $clog2(RW + 1);

    logic [btsc_pkg::SQRT_IN_W-1:0] rad_reg;
    logic [REM_W-1:0]               rem_reg;
    logic [RW-1:0]                  root_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    logic [REM_W+1:0]               rem_sh;
    logic [REM_W+1:0]               trial;
    logic [REM_W+1:0]               rem_sub;
    logic                           ge;

    always_comb
    begin
        rem_sh  = {rem_reg, rad_reg[btsc_pkg::SQRT_IN_W-1 -: 2]};
        trial   = {2'b00, root_reg, 2'b01};
        ge      = rem_sh >= trial;
        rem_sub = rem_sh - trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(RW);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[btsc_pkg::SQRT_IN_W-3:0], 2'b00};
            rem_reg  <= ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
            root_reg <= {root_reg[RW-2:0], ge};
        end
    end

    assign root      = root_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

// File: rtl/box_tracking_stick_controller_core.sv
// Channel   Signals                               Dir  Notes
// in        in_valid/in_ready + box, joy fields   in   one control tick per request
// out       out_valid/out_ready + stick fields    out  zero or one result per request
// cfg       cfg_we/cfg_index/cfg_data             in   write only, no wait
//
// Joystick requests pass through ST_OUT into the output register once it is free.
// Tracking requests run a bit-pair square root and up to five 56-bit divisions on one
// bit-serial divider; the ratio division is skipped when full_error is zero and the
// thrust division when the box centre is above the aim row.
// A request without joystick data or a box above min_conf is dropped in its accept cycle.
// A new request is taken while the previous result waits in the output register.
// rst_n clears control and filter state and loads configuration defaults asynchronously.
`default_nettype none

module box_tracking_stick_controller_core #(
    parameter int FRAME_WIDTH  = 640,
    parameter int FRAME_HEIGHT = 480
) (
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,

    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               box_seen,
    input  wire logic [9:0]         left_px,
    input  wire logic [9:0]         right_px,
    input  wire logic [9:0]         top_px,
    input  wire logic [9:0]         bottom_px,
    input  wire logic [15:0]        confidence,
    input  wire logic               joy_seen,
    input  wire logic signed [15:0] axis_fore_aft,
    input  wire logic signed [15:0] axis_side,
    input  wire logic signed [15:0] axis_throttle,
    input  wire logic signed [15:0] axis_turn,

    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [10:0]      stick_x,
    output logic signed [10:0]      stick_y,
    output logic [9:0]              stick_z,
    output logic signed [10:0]      stick_r,
    output logic                    from_tracker
);

    localparam int NW = btsc_pkg::DIV_NUM_W;
    localparam int DW = btsc_pkg::DIV_DEN_W;

    localparam longint unsigned ROLL_DEN  = 64'(FRAME_WIDTH) * btsc_pkg::TILT_Q24;
    localparam longint unsigned PITCH_DEN = 64'(FRAME_HEIGHT) * btsc_pkg::TILT_Q24;
    localparam logic [DW-1:0] ROLL_DEN_W  = DW'(ROLL_DEN);
    localparam logic [DW-1:0] PITCH_DEN_W = DW'(PITCH_DEN);
    localparam logic [NW-1:0] ROLL_HALF   = NW'(ROLL_DEN / 2);
    localparam logic [NW-1:0] PITCH_HALF  = NW'(PITCH_DEN / 2);
    localparam logic [DW-1:0] YAW_DEN_W   = DW'(FRAME_WIDTH);
    localparam logic [DW-1:0] THR_DEN_W   = DW'(FRAME_HEIGHT);
    localparam logic [NW-1:0] YAW_HALF    = NW'(FRAME_WIDTH / 2);
    localparam logic [NW-1:0] THR_HALF    = NW'(FRAME_HEIGHT / 2);

    // configuration
    logic [15:0] alpha_min_reg;
    logic [15:0] alpha_max_reg;
    logic [9:0]  full_error_reg;
    logic [15:0] tilt_gain_reg;
    logic [15:0] turn_gain_reg;
    logic [9:0]  aim_x_reg;
    logic [9:0]  aim_y_reg;
    logic [15:0] min_conf_reg;

    btsc_pkg::state_t state_reg;
    btsc_pkg::state_t state_next;

    logic                     track_reg;
    logic [1:0]               op_reg;
    logic [1:0]               ch_reg;
    logic signed [11:0]       dx2_reg;
    logic signed [11:0]       dy2_reg;
    logic signed [15:0]       fa_reg;
    logic signed [15:0]       sd_reg;
    logic signed [15:0]       th_reg;
    logic signed [15:0]       tn_reg;
    logic [16:0]              ratio_reg;
    logic signed [34:0]       prod_reg;
    logic [15:0]              alpha_reg;
    logic signed [17:0]       u_reg [4];
    logic signed [17:0]       s_reg [4];
    logic signed [34:0]       p1_reg;
    logic signed [35:0]       p2_reg;

    logic                     out_valid_reg;
    logic signed [10:0]       stick_x_reg;
    logic signed [10:0]       stick_y_reg;
    logic [9:0]               stick_z_reg;
    logic signed [10:0]       stick_r_reg;
    logic                     from_tracker_reg;

    // units
    logic                          sqrt_start;
    logic [btsc_pkg::SQRT_IN_W-1:0] sqrt_rad;
    logic [btsc_pkg::SQRT_ROOT_W-1:0] sqrt_root;
    btsc_pkg::unit_stat_t          sqrt_stat;
    logic                          div_start;
    logic [NW-1:0]                 div_num;
    logic [DW-1:0]                 div_den;
    logic [NW-1:0]                 div_quo;
    btsc_pkg::unit_stat_t          div_stat;

    logic                     in_acc;
    logic                     track_now;
    logic                     out_free;
    logic                     out_load;
    logic                     thr_skip;
    logic signed [12:0]       dx2_wide;
    logic signed [12:0]       dy2_wide;
    logic [11:0]              adx;
    logic [11:0]              ady;
    logic signed [23:0]       sqx;
    logic signed [23:0]       sqy;
    logic [27:0]              tg_dx;
    logic [27:0]              tg_dy;
    logic [27:0]              yg_dx;
    logic [33:0]              yaw_mag;
    logic [28:0]              thr_mag;
    logic signed [31:0]       q32;
    logic signed [17:0]       div_u;
    logic signed [17:0]       cur_u;
    logic signed [17:0]       cur_s;
    logic signed [36:0]       filt_sum;
    logic signed [35:0]       alpha_sum;

    function automatic logic signed [17:0] sat_sym(input logic signed [31:0] v);
        logic signed [31:0] r;
        begin
            if (v > 32'(btsc_pkg::ONE_Q16))
                r = 32'(btsc_pkg::ONE_Q16);
            else if (v < -32'(btsc_pkg::ONE_Q16))
                r = -32'(btsc_pkg::ONE_Q16);
            else
                r = v;
            return r[17:0];
        end
    endfunction

    function automatic logic signed [17:0] sat_pos(input logic signed [31:0] v);
        logic signed [31:0] r;
        begin
            if (v > 32'(btsc_pkg::ONE_Q16))
                r = 32'(btsc_pkg::ONE_Q16);
            else if (v < 32'sd0)
                r = 32'sd0;
            else
                r = v;
            return r[17:0];
        end
    endfunction

    // s * 1000 / 2^16, rounded half away from zero
    function automatic logic signed [10:0] stick_of(input logic signed [17:0] s);
        logic [17:0] mag;
        logic [26:0] m;
        logic [10:0] r;
        begin
            mag = s[17] ? 18'(-s) : 18'(s);
            m   = 27'(mag[16:0]) * 27'd1000 + 27'd32768;
            r   = m[26:16];
            return s[17] ? 11'(-r) : r;
        end
    endfunction

    // a * 1000 / 2^14, rounded half away from zero, saturated to +-1000
    function automatic logic signed [10:0] joy_axis(input logic signed [15:0] a,
                                                    input logic flip);
        logic [16:0] mag;
        logic [26:0] m;
        logic [12:0] r;
        logic [10:0] c;
        begin
            mag = a[15] ? 17'(-$signed({a[15], a})) : {1'b0, a};
            m   = 27'(mag) * 27'd1000 + 27'd8192;
            r   = m[26:14];
            c   = (r > 13'd1000) ? 11'd1000 : r[10:0];
            return (a[15] ^ flip) ? 11'(-c) : c;
        end
    endfunction

    // (a + 1) / 2 * 1000 over Q1.14, clamped to 0..1000
    function automatic logic [9:0] joy_z(input logic signed [15:0] a);
        logic signed [16:0] w;
        logic [26:0]        m;
        logic [11:0]        r;
        begin
            w = $signed({a[15], a}) + 17'sd16384;
            m = 27'(w[15:0]) * 27'd1000 + 27'd16384;
            r = m[26:15];
            if (w[16])
                return 10'd0;
            else if (r > 12'd1000)
                return 10'd1000;
            else
                return r[9:0];
        end
    endfunction

    btsc_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .rad   (sqrt_rad),
        .root  (sqrt_root),
        .stat  (sqrt_stat)
    );

    btsc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .stat  (div_stat)
    );

    // datapath helpers
    always_comb
    begin
        in_acc    = in_valid && in_ready;
        track_now = box_seen && (confidence > min_conf_reg);
        out_free  = !out_valid_reg || out_ready;
        thr_skip  = !dy2_reg[11] && (dy2_reg != 12'sd0);

        dx2_wide = $signed({2'b00, aim_x_reg, 1'b0}) - $signed({3'b000, left_px})
                   - $signed({3'b000, right_px});
        dy2_wide = $signed({2'b00, aim_y_reg, 1'b0}) - $signed({3'b000, top_px})
                   - $signed({3'b000, bottom_px});

        adx = dx2_reg[11] ? 12'(-dx2_reg) : 12'(dx2_reg);
        ady = dy2_reg[11] ? 12'(-dy2_reg) : 12'(dy2_reg);

        sqx      = dx2_reg * dx2_reg;
        sqy      = dy2_reg * dy2_reg;
        sqrt_rad = {24'(sqx) + 24'(sqy), 32'd0};

        tg_dx   = 28'(tilt_gain_reg) * 28'(adx);
        tg_dy   = 28'(tilt_gain_reg) * 28'(ady);
        yg_dx   = 28'(turn_gain_reg) * 28'(adx);
        yaw_mag = ({6'd0, yg_dx} << 5) + ({6'd0, yg_dx} << 3);
        thr_mag = 29'(({2'b00, ady} << 2) + {2'b00, ady}) << 15;

        q32 = $signed({2'b00, div_quo[29:0]});
        case (op_reg)
            btsc_pkg::CH_ROLL:
                div_u = sat_sym(dx2_reg[11] ? -q32 : q32);
            btsc_pkg::CH_PITCH:
                div_u = sat_sym(32'(btsc_pkg::PITCH_OFFSET_Q16)
                                - (dy2_reg[11] ? -q32 : q32));
            btsc_pkg::CH_YAW:
                div_u = sat_sym(dx2_reg[11] ? q32 : -q32);
            btsc_pkg::CH_THR:
                div_u = sat_pos(32'(btsc_pkg::HALF_Q16) - q32);
            default:
                div_u = '0;
        endcase

        cur_u     = u_reg[ch_reg];
        cur_s     = s_reg[ch_reg];
        filt_sum  = 37'(p1_reg) + 37'(p2_reg) + 37'sd32768;
        alpha_sum = $signed({20'd0, alpha_min_reg})
                    + ((36'(prod_reg) + 36'sd32768) >>> 16);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            btsc_pkg::ST_IDLE:
                if (in_acc)
                begin
                    if (track_now)
                        state_next = btsc_pkg::ST_PREP;
                    else if (joy_seen)
                        state_next = btsc_pkg::ST_OUT;
                end
            btsc_pkg::ST_PREP:
                state_next = btsc_pkg::ST_SQRT;
            btsc_pkg::ST_SQRT:
                if (sqrt_stat.done)
                    state_next = btsc_pkg::ST_RATIO_GO;
            btsc_pkg::ST_RATIO_GO:
                state_next = (full_error_reg == 10'd0) ? btsc_pkg::ST_ALPHA_MUL
                                                       : btsc_pkg::ST_RATIO;
            btsc_pkg::ST_RATIO:
                if (div_stat.done)
                    state_next = btsc_pkg::ST_ALPHA_MUL;
            btsc_pkg::ST_ALPHA_MUL:
                state_next = btsc_pkg::ST_ALPHA;
            btsc_pkg::ST_ALPHA:
                state_next = btsc_pkg::ST_DIV_GO;
            btsc_pkg::ST_DIV_GO:
                if (op_reg == btsc_pkg::CH_THR && thr_skip)
                    state_next = btsc_pkg::ST_FILT_MUL;
                else
                    state_next = btsc_pkg::ST_DIV;
            btsc_pkg::ST_DIV:
                if (div_stat.done)
                    state_next = (op_reg == btsc_pkg::CH_THR) ? btsc_pkg::ST_FILT_MUL
                                                              : btsc_pkg::ST_DIV_GO;
            btsc_pkg::ST_FILT_MUL:
                state_next = btsc_pkg::ST_FILT_ADD;
            btsc_pkg::ST_FILT_ADD:
                state_next = (ch_reg == btsc_pkg::CH_THR) ? btsc_pkg::ST_OUT
                                                          : btsc_pkg::ST_FILT_MUL;
            btsc_pkg::ST_OUT:
                if (out_free)
                    state_next = btsc_pkg::ST_IDLE;
            default:
                state_next = btsc_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready   = 1'b0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        div_num    = '0;
        div_den    = '0;
        case (state_reg)
            btsc_pkg::ST_IDLE:
                in_ready = 1'b1;
            btsc_pkg::ST_PREP:
                sqrt_start = 1'b1;
            btsc_pkg::ST_RATIO_GO:
            begin
                div_start = full_error_reg != 10'd0;
                div_num   = NW'(sqrt_root);
                div_den   = DW'({full_error_reg, 1'b0});
            end
            btsc_pkg::ST_DIV_GO:
            begin
                case (op_reg)
                    btsc_pkg::CH_ROLL:
                    begin
                        div_num = {1'b0, tg_dx, 27'd0} + ROLL_HALF;
                        div_den = ROLL_DEN_W;
                    end
                    btsc_pkg::CH_PITCH:
                    begin
                        div_num = {1'b0, tg_dy, 27'd0} + PITCH_HALF;
                        div_den = PITCH_DEN_W;
                    end
                    btsc_pkg::CH_YAW:
                    begin
                        div_num = NW'(yaw_mag) + YAW_HALF;
                        div_den = YAW_DEN_W;
                    end
                    btsc_pkg::CH_THR:
                    begin
                        div_num = NW'(thr_mag) + THR_HALF;
                        div_den = THR_DEN_W;
                    end
                    default:
                    begin
                        div_num = '0;
                        div_den = '0;
                    end
                endcase
                div_start = !(op_reg == btsc_pkg::CH_THR && thr_skip);
            end
            btsc_pkg::ST_OUT:
                out_load = out_free;
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= btsc_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_min_reg  <= 16'd13107;
            alpha_max_reg  <= 16'd52429;
            full_error_reg <= 10'd200;
            tilt_gain_reg  <= 16'd410;
            turn_gain_reg  <= 16'd2048;
            aim_x_reg      <= 10'd320;
            aim_y_reg      <= 10'd240;
            min_conf_reg   <= 16'd13107;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                btsc_pkg::REG_ALPHA_MIN:  alpha_min_reg  <= cfg_data;
                btsc_pkg::REG_ALPHA_MAX:  alpha_max_reg  <= cfg_data;
                btsc_pkg::REG_FULL_ERROR: full_error_reg <= cfg_data[9:0];
                btsc_pkg::REG_TILT_GAIN:  tilt_gain_reg  <= cfg_data;
                btsc_pkg::REG_TURN_GAIN:  turn_gain_reg  <= cfg_data;
                btsc_pkg::REG_AIM_X:      aim_x_reg      <= cfg_data[9:0];
                btsc_pkg::REG_AIM_Y:      aim_y_reg      <= cfg_data[9:0];
                btsc_pkg::REG_MIN_CONF:   min_conf_reg   <= cfg_data;
                default:                  min_conf_reg   <= min_conf_reg;
            endcase
        end
    end

    // control and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_reg     <= 1'b0;
            op_reg        <= btsc_pkg::CH_ROLL;
            ch_reg        <= btsc_pkg::CH_ROLL;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
                s_reg[i] <= '0;
        end
        else
        begin
            if (in_acc)
                track_reg <= track_now;
            if (state_reg == btsc_pkg::ST_ALPHA)
                op_reg <= btsc_pkg::CH_ROLL;
            else if (state_reg == btsc_pkg::ST_DIV && div_stat.done)
                op_reg <= op_reg + 2'd1;
            if (state_reg == btsc_pkg::ST_ALPHA)
                ch_reg <= btsc_pkg::CH_ROLL;
            else if (state_reg == btsc_pkg::ST_FILT_ADD)
            begin
                ch_reg        <= ch_reg + 2'd1;
                s_reg[ch_reg] <= filt_sum[33:16];
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            dx2_reg <= dx2_wide[11:0];
            dy2_reg <= dy2_wide[11:0];
            fa_reg  <= axis_fore_aft;
            sd_reg  <= axis_side;
            th_reg  <= axis_throttle;
            tn_reg  <= axis_turn;
        end
        if (state_reg == btsc_pkg::ST_RATIO_GO && full_error_reg == 10'd0)
            ratio_reg <= 17'(btsc_pkg::ONE_Q16);
        else if (state_reg == btsc_pkg::ST_RATIO && div_stat.done)
            ratio_reg <= (div_quo >= NW'(btsc_pkg::ONE_Q16)) ? 17'(btsc_pkg::ONE_Q16)
                                                             : div_quo[16:0];
        if (state_reg == btsc_pkg::ST_ALPHA_MUL)
            prod_reg <= ($signed({1'b0, alpha_max_reg}) - $signed({1'b0, alpha_min_reg}))
                        * $signed({1'b0, ratio_reg});
        if (state_reg == btsc_pkg::ST_ALPHA)
            alpha_reg <= alpha_sum[15:0];
        if (state_reg == btsc_pkg::ST_DIV_GO && op_reg == btsc_pkg::CH_THR && thr_skip)
            u_reg[btsc_pkg::CH_THR] <= 18'(btsc_pkg::HALF_Q16);
        else if (state_reg == btsc_pkg::ST_DIV && div_stat.done)
            u_reg[op_reg] <= div_u;
        if (state_reg == btsc_pkg::ST_FILT_MUL)
        begin
            p1_reg <= $signed({1'b0, alpha_reg}) * cur_u;
            p2_reg <= $signed({1'b0, 17'(17'h10000 - {1'b0, alpha_reg})}) * cur_s;
        end
        if (out_load)
        begin
            from_tracker_reg <= track_reg;
            if (track_reg)
            begin
                stick_x_reg <= stick_of(s_reg[btsc_pkg::CH_PITCH]);
                stick_y_reg <= stick_of(s_reg[btsc_pkg::CH_ROLL]);
                stick_z_reg <= 10'(stick_of(s_reg[btsc_pkg::CH_THR]));
                stick_r_reg <= stick_of(s_reg[btsc_pkg::CH_YAW]);
            end
            else
            begin
                stick_x_reg <= joy_axis(fa_reg, 1'b0);
                stick_y_reg <= joy_axis(sd_reg, 1'b1);
                stick_z_reg <= joy_z(th_reg);
                stick_r_reg <= joy_axis(tn_reg, 1'b1);
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign stick_x      = stick_x_reg;
    assign stick_y      = stick_y_reg;
    assign stick_z      = stick_z_reg;
    assign stick_r      = stick_r_reg;
    assign from_tracker = from_tracker_reg;

endmodule

`default_nettype wire

// File: rtl/btsc_chk.sv
`default_nettype none

`include "box_tracking_stick_controller_core_assert.svh"

module btsc_chk (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               joy_seen,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [10:0] stick_x,
    input wire logic [9:0]         stick_z
);

    `BTSC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `BTSC_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready && joy_seen, !in_ready)
    `BTSC_ASSERT_NOW(a_z_range, out_valid, stick_z <= 10'd1000)
    `BTSC_ASSERT_NOW(a_x_range, out_valid, stick_x >= -11'sd1000 && stick_x <= 11'sd1000)

endmodule

bind box_tracking_stick_controller_core btsc_chk u_btsc_chk (.*);

`default_nettype wire
